/* src/sitda_pkg.sv */
// sitda_pkg: shared types and constants for the signed integer to decimal ASCII block.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGITS   = 10;
    localparam int CHAR_W   = 6;
    localparam int DIGIT_W  = 4;
    localparam int BCD_W    = DIGITS * DIGIT_W;
    localparam int SHIFT_W  = $clog2(VALUE_W);
    localparam int IDX_W    = $clog2(DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // One classified number: sign flag and unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

    // Queue status seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

/* src/sitda_front.sv */
// sitda_front: input stage; registers one beat and splits it into sign and magnitude.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [31:0]           value,
    input  sitda_pkg::fifo_stat_t        fifo_stat,
    output logic                         push,
    output sitda_pkg::item_t             push_item
);
    import sitda_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    // Two's complement magnitude; the most negative value comes out as 2^31 unsigned.
    always_comb
    begin
        item_next.neg = value[VALUE_W-1];
        item_next.mag = value[VALUE_W-1] ? (~value + 32'd1) : value;
    end

    assign push      = valid_reg && !fifo_stat.full;
    assign in_stall  = valid_reg && fifo_stat.full;
    assign accept    = in_valid && !in_stall;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* src/sitda_fifo.sv */
// sitda_fifo: two-entry queue of classified numbers between front and back.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sitda_pkg::item_t      push_item,
    input  logic                  pop,
    output sitda_pkg::item_t      head_item,
    output sitda_pkg::fifo_stat_t stat
);
    import sitda_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/sitda_back.sv */
// sitda_back: bit-serial double-dabble converter and character emitter.
// Depends on sitda_pkg; takes items from sitda_fifo.
`timescale 1ns / 1ps

module sitda_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sitda_pkg::fifo_stat_t        fifo_stat,
    input  sitda_pkg::item_t             head_item,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sitda_pkg::CHAR_W-1:0] character,
    output logic                         last_char
);
    import sitda_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic [VALUE_W-1:0]            mag_reg;
    logic [DIGITS-1:0][DIGIT_W-1:0] bcd_reg;
    logic [DIGITS-1:0][DIGIT_W-1:0] bcd_adj;
    logic [SHIFT_W-1:0]            shift_cnt_reg;
    logic                          minus_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              top_idx;
    logic                          out_valid_reg;
    logic [CHAR_W-1:0]             char_reg;
    logic                          last_reg;
    logic                          out_free;
    logic                          emit_now;
    logic [DIGIT_W-1:0]            cur_digit;

    // Add 3 to every digit of 5 or more before each shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    // Highest nonzero digit; zero keeps index 0 so a lone '0' goes out.
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign pop       = (state_reg == ST_IDLE) && !fifo_stat.empty;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_now  = (state_reg == ST_EMIT) && out_free;
    assign cur_digit = bcd_reg[idx_reg];

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mag_reg       <= '0;
            bcd_reg       <= '0;
            shift_cnt_reg <= '0;
            minus_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // Drop the output beat once taken, unless a new one replaces it.
            if (!emit_now && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        mag_reg       <= head_item.mag;
                        minus_reg     <= head_item.neg;
                        bcd_reg       <= '0;
                        shift_cnt_reg <= SHIFT_W'(VALUE_W - 1);
                        state_reg     <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    {bcd_reg, mag_reg} <= {bcd_adj[DIGITS-1:0], mag_reg} << 1;
                    shift_cnt_reg      <= shift_cnt_reg - 1'b1;
                    if (shift_cnt_reg == '0)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    idx_reg   <= top_idx;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_now)
                    begin
                        out_valid_reg <= 1'b1;
                        if (minus_reg)
                        begin
                            char_reg  <= CHAR_MINUS;
                            last_reg  <= 1'b0;
                            minus_reg <= 1'b0;
                        end
                        else
                        begin
                            char_reg <= CHAR_ZERO + {2'b00, cur_digit};
                            last_reg <= (idx_reg == '0);
                            if (idx_reg == '0)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg - 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// signed_int_to_decimal_ascii: top level; signed 32-bit integer to decimal ASCII text.
// Depends on sitda_pkg, sitda_front, sitda_fifo and sitda_back.
`timescale 1ns / 1ps

// Each input beat carries one signed 32-bit value; the block returns its decimal text
// as one output beat per character, most significant first: a '-' for negative values,
// then the digits with no leading zeros ('0' alone for zero). last_char marks the final
// character of each number. The most negative value gives "-2147483648". The front
// stage registers a beat and forms sign and magnitude, a two-entry queue holds up to two
// more numbers, and the back converts one number at a time with a bit-serial
// double-dabble shifter of 32 steps, a scan state to find the leading digit, then one
// character per cycle while the output is not stalled. Input beats keep being taken
// while the back works, until the queue and the front register are full; output stall
// holds the character output (and the back in its emit state) without losing data.
module signed_int_to_decimal_ascii
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [31:0]           value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sitda_pkg::CHAR_W-1:0] character,
    output logic                         last_char
);
    import sitda_pkg::*;

    logic       push;
    logic       pop;
    item_t      push_item;
    item_t      head_item;
    fifo_stat_t fifo_stat;

    // Front: hold one beat, classify sign, form magnitude.
    sitda_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_item (push_item)
    );

    // Queue: decouple input acceptance from the slow conversion.
    sitda_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (fifo_stat)
    );

    // Back: convert to BCD and stream characters out.
    sitda_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .head_item (head_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last_char (last_char)
    );

endmodule

/* tb/sv/sitda_text_check_pkg.sv */
// sitda_text_check_pkg: expected-text store for the signed integer to decimal ASCII block.
// Holds the decimal text predictor and the character checker; depends on sitda_pkg.
`timescale 1ns / 1ps

package sitda_text_check_pkg;

    import sitda_pkg::*;

    localparam logic [VALUE_W-1:0] RADIX       = 32'd10;
    localparam int                 REPORT_CAP  = 50;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_beat_t;

    class text_scoreboard;
        text_beat_t expected_text[$];
        int         errors;
        int         numbers_seen;
        int         negatives_seen;
        int         chars_seen;

        function new();
            errors         = 0;
            numbers_seen   = 0;
            negatives_seen = 0;
            chars_seen     = 0;
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        // Queue the decimal text of one accepted value, most significant character first.
        function void note_value(logic signed [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] raw;
            logic [VALUE_W-1:0] mag;
            logic [DIGIT_W-1:0] digs [DIGITS];
            int                 nd;
            text_beat_t         beat;

            raw = value;
            // The most negative value wraps to 2^31, which is still right as unsigned.
            mag = raw[VALUE_W-1] ? (~raw + 32'd1) : raw;
            nd  = 0;
            do
            begin
                digs[nd] = DIGIT_W'(mag % RADIX);
                mag      = mag / RADIX;
                nd++;
            end
            while (mag != 0 && nd < DIGITS);

            numbers_seen++;
            if (raw[VALUE_W-1])
            begin
                negatives_seen++;
                beat.code = CHAR_MINUS;
                beat.last = 1'b0;
                expected_text.push_back(beat);
            end
            for (int k = nd - 1; k >= 0; k--)
            begin
                beat.code = CHAR_ZERO + CHAR_W'(digs[k]);
                beat.last = (k == 0);
                expected_text.push_back(beat);
            end
        endfunction

        // Compare one accepted output beat with the oldest expected character.
        function void check_char(logic [CHAR_W-1:0] code, logic last);
            text_beat_t want;

            chars_seen++;
            if (expected_text.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected character: expected none, got code %0d last %b",
                             $time, code, last);
                return;
            end
            want = expected_text.pop_front();
            if (code !== want.code)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: character mismatch: expected %0d, got %0d",
                             $time, want.code, code);
            end
            if (last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: last_char mismatch: expected %b, got %b",
                             $time, want.last, last);
            end
        endfunction
    endclass

endpackage

/* tb/sv/tb.sv */
// tb: top-level testbench for signed_int_to_decimal_ascii.
// Drives signed values with random gaps and output stalls; checks every character beat.
// Depends on sitda_pkg and sitda_text_check_pkg.
`timescale 1ns / 1ps

module tb;

    import sitda_pkg::*;
    import sitda_text_check_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 3;
    // Extra wait after the last expected character, so the back can settle.
    localparam int DRAIN_TAIL     = 60;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_ITEMS     = 12;
    localparam int RANDOM_CHUNKS  = 6;
    localparam int CHUNK_ITEMS    = 25;
    // Longest legal quiet stretch is the output hold plus a long gap and one conversion.
    localparam int WATCHDOG_LIMIT = 4000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [VALUE_W-1:0]  value;
    logic                       out_valid;
    logic                       out_stall;
    logic [CHAR_W-1:0]          character;
    logic                       last_char;

    text_scoreboard sb = new();

    // calm removes idling on both sides; hold_request asks the receiver for a long hold-off.
    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    int idle_cycles  = 0;

    signed_int_to_decimal_ascii DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last_char (last_char)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;

        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [VALUE_W-1:0] power_of_ten(int k);
        logic signed [VALUE_W-1:0] p;

        p = 1;
        repeat (k)
            p = p * 10;
        return p;
    endfunction

    // Random value: full-width noise, small numbers, digit-count boundaries and extremes.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;

        case ($urandom_range(0, 5))
            0, 1:
                v = $urandom;
            2:
                v = $signed($urandom_range(0, 2000)) - 1000;
            3:
            begin
                // Land on or next to a power of ten, where the digit count changes.
                v = power_of_ten($urandom_range(0, DIGITS - 1)) +
                    $signed($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            4:
                v = $signed($urandom_range(0, 9)) * ($urandom_range(0, 1) ? -1 : 1);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7fff_ffff;
                    2:       v = 32'sh8000_0001;
                    default: v = 32'sh0000_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offer one beat after a random gap and hold it until the block takes it.
    // Call right after a rising edge; returns at the edge that accepted the beat.
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        int gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Pause the sender until every expected character has come, then let the back settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL)
            @(posedge clk);
    endtask

    // Reset once, then stimulus: directed values, a long output hold, random chunks.
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero, one-digit values, digit-count boundaries and both extremes.
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(10);
        send_value(-10);
        send_value(99);
        send_value(100);
        send_value(-7);
        send_value(123456789);
        send_value(-123456789);
        send_value(999999999);
        send_value(1000000000);
        send_value(-999999999);
        send_value(-1000000000);
        send_value(32'sh7fff_ffff);
        send_value(32'sh8000_0000);
        send_value(32'sh8000_0001);
        send_value(32'sh5555_5555);
        send_value(32'shaaaa_aaaa);

        // Sender pause: let every expected character come out before going on.
        wait_drained();

        // Long receiver hold-off while the sender keeps offering back to back,
        // so the front register and the queue fill and the input stalls.
        hold_request = 1'b1;
        calm         = 1'b1;
        repeat (HOLD_ITEMS)
            send_value(pick_value());
        calm = 1'b0;

        // Random chunks; one chunk runs with no idling on either side.
        for (int c = 0; c < RANDOM_CHUNKS; c++)
        begin
            calm = (c == 2);
            repeat (CHUNK_ITEMS)
                send_value(pick_value());
        end
        calm = 1'b0;

        wait_drained();

        $display("converted %0d numbers (%0d negative) into %0d characters",
                 sb.numbers_seen, sb.negatives_seen, sb.chars_seen);
        $display("covered extremes, digit-count boundaries, a %0d-cycle output hold and a drain pause",
                 LONG_HOLD);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver: random stall stretches, plus one long hold-off when asked.
    initial
    begin
        int gap;

        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap)
                        @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
        end
    end

    // Monitor both channels at the edge and run the watchdog on accepted beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_value(value);
            if (out_valid && !out_stall)
                sb.check_char(character, last_char);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
src/sitda_pkg.sv
src/sitda_front.sv
src/sitda_fifo.sv
src/sitda_back.sv
src/signed_int_to_decimal_ascii.sv
tb/sv/sitda_text_check_pkg.sv
tb/sv/tb.sv
